FILE: design/sfd_pkg.sv
// Shared constants and types for the serial frame deframer.
`timescale 1ns / 1ps

package sfd_pkg;

    localparam int BYTE_W  = 8;
    localparam int LIMIT_W = 16;
    localparam int LEN_W   = 17;
    localparam int POS_W   = 16;
    localparam int ADDR_W  = 5;
    localparam int APB_W   = 32;

    localparam int RESULT_W = 1 + POS_W + BYTE_W + 1 + LEN_W + 1;
    localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;
    localparam int PAD_W    = TDATA_W - RESULT_W;

    typedef enum logic [2:0] {
        REG_FIRST_HEADER  = 3'd0,
        REG_SECOND_HEADER = 3'd1,
        REG_MIN_LEN       = 3'd2,
        REG_MAX_LEN       = 3'd3,
        REG_BUFFER_LIMIT  = 3'd4
    } reg_index_t;

    localparam logic [BYTE_W-1:0]  FIRST_HEADER_RST  = 8'd0;
    localparam logic [BYTE_W-1:0]  SECOND_HEADER_RST = 8'd0;
    localparam logic [BYTE_W-1:0]  MIN_LEN_RST       = 8'd1;
    localparam logic [BYTE_W-1:0]  MAX_LEN_RST       = 8'd255;
    localparam logic [LIMIT_W-1:0] BUFFER_LIMIT_RST  = 16'd512;

    localparam logic [LEN_W-1:0] HEADER_BYTES = 17'd3;
    localparam logic [LEN_W-1:0] EXT_LOW_POS  = 17'd9;
    localparam logic [LEN_W-1:0] EXT_HIGH_POS = 17'd10;
    localparam logic [LEN_W-1:0] EXT_EXTRA    = 17'd2;

    localparam logic [LEN_W-1:0] POS_HEADER1 = 17'd0;
    localparam logic [LEN_W-1:0] POS_HEADER2 = 17'd1;
    localparam logic [LEN_W-1:0] POS_LENGTH  = 17'd2;

    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // Packed so that write_valid sits in the lowest bit of tdata.
    typedef struct packed {
        logic [PAD_W-1:0]  pad;
        logic              frame_dropped;
        logic [LEN_W-1:0]  frame_length;
        logic              frame_complete;
        logic [BYTE_W-1:0] write_value;
        logic [POS_W-1:0]  write_position;
        logic              write_valid;
    } result_t;

endpackage

FILE: design/serial_frame_deframer.sv
// Top level of the serial frame deframer with its configuration registers.
`timescale 1ns / 1ps

// The deframer takes one word per cycle on the slave side while the master side keeps up, and
// gives exactly one registered result word for each through an output register backed by a
// one-word skid stage; the frame parser state is updated in the same cycle the word is taken,
// so a word can be accepted every cycle while the master side keeps up. A word with tuser high
// always returns the parser to idle, which releases a completed frame. Registers are to be
// written over the APB port only while no word is in flight; the block does not enforce this.
module serial_frame_deframer
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sfd_pkg::ADDR_W-1:0]      paddr,
    input  logic [sfd_pkg::APB_W-1:0]       pwdata,
    output logic [sfd_pkg::APB_W-1:0]       prdata,
    output logic                            pready,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sfd_pkg::BYTE_W-1:0]      s_tdata,  // data_byte
    input  logic                            s_tuser,  // kind

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // write_valid, write_position, write_value, frame_complete, frame_length,
    // frame_dropped, zero padding
    output logic [sfd_pkg::TDATA_W-1:0]     m_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD1,
        ST_HEAD2,
        ST_DATA,
        ST_DONE
    } mode_t;

    logic [sfd_pkg::BYTE_W-1:0]  first_header_reg;
    logic [sfd_pkg::BYTE_W-1:0]  second_header_reg;
    logic [sfd_pkg::BYTE_W-1:0]  min_len_reg;
    logic [sfd_pkg::BYTE_W-1:0]  max_len_reg;
    logic [sfd_pkg::LIMIT_W-1:0] buffer_limit_reg;

    mode_t                       mode_reg, mode_next;
    logic [sfd_pkg::LEN_W-1:0]   pos_reg, pos_next;
    logic [sfd_pkg::LEN_W-1:0]   exp_len_reg, exp_len_next;
    logic                        ext_reg, ext_next;

    sfd_pkg::result_t            result;
    sfd_pkg::result_t            out_reg;
    sfd_pkg::result_t            skid_reg;
    logic                        out_valid_reg;
    logic                        skid_valid_reg;

    logic                        cfg_write;
    sfd_pkg::reg_index_t         cfg_index;
    logic                        in_fire;
    logic                        out_fire;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign cfg_index = sfd_pkg::reg_index_t'(paddr[sfd_pkg::ADDR_W-1:2]);

    always_comb
    begin
        unique case (cfg_index)
            sfd_pkg::REG_FIRST_HEADER:
                prdata = {{(sfd_pkg::APB_W - sfd_pkg::BYTE_W){1'b0}}, first_header_reg};
            sfd_pkg::REG_SECOND_HEADER:
                prdata = {{(sfd_pkg::APB_W - sfd_pkg::BYTE_W){1'b0}}, second_header_reg};
            sfd_pkg::REG_MIN_LEN:
                prdata = {{(sfd_pkg::APB_W - sfd_pkg::BYTE_W){1'b0}}, min_len_reg};
            sfd_pkg::REG_MAX_LEN:
                prdata = {{(sfd_pkg::APB_W - sfd_pkg::BYTE_W){1'b0}}, max_len_reg};
            sfd_pkg::REG_BUFFER_LIMIT:
                prdata = {{(sfd_pkg::APB_W - sfd_pkg::LIMIT_W){1'b0}}, buffer_limit_reg};
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_header_reg  <= sfd_pkg::FIRST_HEADER_RST;
            second_header_reg <= sfd_pkg::SECOND_HEADER_RST;
            min_len_reg       <= sfd_pkg::MIN_LEN_RST;
            max_len_reg       <= sfd_pkg::MAX_LEN_RST;
            buffer_limit_reg  <= sfd_pkg::BUFFER_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sfd_pkg::REG_FIRST_HEADER:  first_header_reg  <= pwdata[sfd_pkg::BYTE_W-1:0];
                sfd_pkg::REG_SECOND_HEADER: second_header_reg <= pwdata[sfd_pkg::BYTE_W-1:0];
                sfd_pkg::REG_MIN_LEN:       min_len_reg       <= pwdata[sfd_pkg::BYTE_W-1:0];
                sfd_pkg::REG_MAX_LEN:       max_len_reg       <= pwdata[sfd_pkg::BYTE_W-1:0];
                sfd_pkg::REG_BUFFER_LIMIT:  buffer_limit_reg  <= pwdata[sfd_pkg::LIMIT_W-1:0];
                default:                    ;
            endcase
        end
    end

    // Frame parser: next state and the result word for the word on the slave side.
    always_comb
    begin
        logic [sfd_pkg::LEN_W-1:0] data_ext;
        logic                      drop;

        data_ext     = {{(sfd_pkg::LEN_W - sfd_pkg::BYTE_W){1'b0}}, s_tdata};
        drop         = 1'b0;
        mode_next    = mode_reg;
        pos_next     = pos_reg;
        exp_len_next = exp_len_reg;
        ext_next     = ext_reg;
        result       = '0;

        if (s_tuser == sfd_pkg::KIND_RELEASE)
        begin
            mode_next    = ST_IDLE;
            pos_next     = '0;
            exp_len_next = '0;
            ext_next     = 1'b0;
        end
        else
        begin
            unique case (mode_reg)
                ST_IDLE:
                begin
                    if (s_tdata == first_header_reg)
                    begin
                        mode_next             = ST_HEAD1;
                        exp_len_next          = '0;
                        ext_next              = 1'b0;
                        pos_next              = sfd_pkg::POS_HEADER2;
                        result.write_valid    = 1'b1;
                        result.write_position = sfd_pkg::POS_HEADER1[sfd_pkg::POS_W-1:0];
                        result.write_value    = s_tdata;
                    end
                end
                ST_HEAD1:
                begin
                    if (s_tdata == second_header_reg)
                    begin
                        mode_next             = ST_HEAD2;
                        pos_next              = sfd_pkg::POS_LENGTH;
                        result.write_valid    = 1'b1;
                        result.write_position = sfd_pkg::POS_HEADER2[sfd_pkg::POS_W-1:0];
                        result.write_value    = s_tdata;
                    end
                    else if (s_tdata != first_header_reg)
                    begin
                        mode_next = ST_IDLE;
                        drop      = 1'b1;
                    end
                end
                ST_HEAD2:
                begin
                    if (s_tdata == '0)
                    begin
                        mode_next    = ST_DATA;
                        exp_len_next = {{(sfd_pkg::LEN_W - sfd_pkg::BYTE_W){1'b0}}, min_len_reg}
                                       + sfd_pkg::HEADER_BYTES;
                        ext_next     = 1'b1;
                    end
                    else if (s_tdata >= min_len_reg && s_tdata <= max_len_reg)
                    begin
                        mode_next    = ST_DATA;
                        exp_len_next = data_ext + sfd_pkg::HEADER_BYTES;
                        ext_next     = 1'b0;
                    end
                    else
                    begin
                        mode_next = ST_IDLE;
                        drop      = 1'b1;
                    end
                    if (!drop)
                    begin
                        pos_next              = sfd_pkg::HEADER_BYTES;
                        result.write_valid    = 1'b1;
                        result.write_position = sfd_pkg::POS_LENGTH[sfd_pkg::POS_W-1:0];
                        result.write_value    = s_tdata;
                    end
                end
                ST_DATA:
                begin
                    if (ext_reg && pos_reg == sfd_pkg::EXT_LOW_POS)
                    begin
                        exp_len_next = exp_len_reg + data_ext;
                    end
                    else if (ext_reg && pos_reg == sfd_pkg::EXT_HIGH_POS)
                    begin
                        exp_len_next = exp_len_reg + (data_ext << 8) + sfd_pkg::EXT_EXTRA;
                        drop = exp_len_next >
                               {{(sfd_pkg::LEN_W - sfd_pkg::LIMIT_W){1'b0}}, buffer_limit_reg};
                    end
                    result.write_valid    = 1'b1;
                    result.write_position = pos_reg[sfd_pkg::POS_W-1:0];
                    result.write_value    = s_tdata;
                    pos_next              = pos_reg + 1'b1;
                    if (drop)
                    begin
                        mode_next = ST_IDLE;
                    end
                    else if (pos_next >= exp_len_next)
                    begin
                        mode_next             = ST_DONE;
                        result.frame_complete = 1'b1;
                    end
                end
                ST_DONE:
                begin
                end
                default:
                begin
                end
            endcase
        end

        result.frame_dropped = drop;
        result.frame_length  = exp_len_next;
    end

    assign s_tready = ~skid_valid_reg;
    assign in_fire  = s_tvalid & s_tready;
    assign out_fire = out_valid_reg & m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= ST_IDLE;
            pos_reg        <= '0;
            exp_len_reg    <= '0;
            ext_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                mode_reg    <= mode_next;
                pos_reg     <= pos_next;
                exp_len_reg <= exp_len_next;
                ext_reg     <= ext_next;
            end

            if (out_fire || !out_valid_reg)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= in_fire;
                end
            end
            else if (in_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Result payload registers; the valid flags above say when they hold a word.
    always_ff @(posedge clk)
    begin
        if (out_fire || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_fire)
            begin
                out_reg <= result;
            end
        end
        else if (in_fire)
        begin
            skid_reg <= result;
        end
    end

endmodule

FILE: design/sfd_checker.sv
// Port-level checks for the serial frame deframer and their binding to it.
`timescale 1ns / 1ps

module sfd_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [sfd_pkg::TDATA_W-1:0] m_tdata
);

    sfd_pkg::result_t res;

    assign res = m_tdata;

    // A stalled result word stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // The slave side only stalls while a result word is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // A word that is not stored carries neither a position nor a value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !res.write_valid |-> res.write_position == '0 && res.write_value == '0)
        else $error("unstored word carries position or value");

    // A frame cannot both complete and be dropped by one word.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(res.frame_complete && res.frame_dropped))
        else $error("frame completed and dropped together");

    // Only a stored byte can complete a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.frame_complete |-> res.write_valid)
        else $error("frame completed without a stored byte");

endmodule

bind serial_frame_deframer sfd_checker u_sfd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: verif/tb_serial_frame_deframer.sv
`timescale 1ns / 1ps
// Self-checking testbench for the serial frame deframer over its stream and APB ports.

module tb_serial_frame_deframer;

    import sfd_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_HEAD1,
        MODE_HEAD2,
        MODE_DATA,
        MODE_END
    } parse_mode_t;

    class frame_scoreboard;
        logic [BYTE_W-1:0]  first_hdr;
        logic [BYTE_W-1:0]  second_hdr;
        logic [BYTE_W-1:0]  min_len;
        logic [BYTE_W-1:0]  max_len;
        logic [LIMIT_W-1:0] limit;
        parse_mode_t        mode;
        logic [LEN_W-1:0]   position;
        logic [LEN_W-1:0]   exp_len;
        logic               ext;
        result_t            pending_q[$];
        int                 failures;
        int                 words_checked;

        function new();
            first_hdr     = FIRST_HEADER_RST;
            second_hdr    = SECOND_HEADER_RST;
            min_len       = MIN_LEN_RST;
            max_len       = MAX_LEN_RST;
            limit         = BUFFER_LIMIT_RST;
            mode          = MODE_IDLE;
            position      = '0;
            exp_len       = '0;
            ext           = 1'b0;
            failures      = 0;
            words_checked = 0;
        endfunction

        function void set_register(reg_index_t idx, logic [APB_W-1:0] value);
            case (idx)
                REG_FIRST_HEADER:  first_hdr  = value[BYTE_W-1:0];
                REG_SECOND_HEADER: second_hdr = value[BYTE_W-1:0];
                REG_MIN_LEN:       min_len    = value[BYTE_W-1:0];
                REG_MAX_LEN:       max_len    = value[BYTE_W-1:0];
                REG_BUFFER_LIMIT:  limit      = value[LIMIT_W-1:0];
                default:           ;
            endcase
        endfunction

        // Advances the parser by one accepted word and queues the result it must produce.
        function void note_word(logic kind, logic [BYTE_W-1:0] b);
            result_t r;
            logic    drop;
            r    = '0;
            drop = 1'b0;
            if (kind == KIND_RELEASE)
            begin
                mode     = MODE_IDLE;
                position = '0;
                exp_len  = '0;
                ext      = 1'b0;
            end
            else
            begin
                case (mode)
                    MODE_IDLE:
                    begin
                        if (b == first_hdr)
                        begin
                            mode             = MODE_HEAD1;
                            exp_len          = '0;
                            ext              = 1'b0;
                            position         = POS_HEADER2;
                            r.write_valid    = 1'b1;
                            r.write_position = POS_HEADER1[POS_W-1:0];
                            r.write_value    = first_hdr;
                        end
                    end
                    MODE_HEAD1:
                    begin
                        if (b == second_hdr)
                        begin
                            mode             = MODE_HEAD2;
                            position         = POS_LENGTH;
                            r.write_valid    = 1'b1;
                            r.write_position = POS_HEADER2[POS_W-1:0];
                            r.write_value    = second_hdr;
                        end
                        else if (b != first_hdr)
                        begin
                            mode = MODE_IDLE;
                            drop = 1'b1;
                        end
                    end
                    MODE_HEAD2:
                    begin
                        if (b == '0 || (b >= min_len && b <= max_len))
                        begin
                            mode             = MODE_DATA;
                            ext              = (b == '0);
                            exp_len          = ((b == '0) ? LEN_W'(min_len) : LEN_W'(b))
                                               + HEADER_BYTES;
                            position         = HEADER_BYTES;
                            r.write_valid    = 1'b1;
                            r.write_position = POS_LENGTH[POS_W-1:0];
                            r.write_value    = b;
                        end
                        else
                        begin
                            mode = MODE_IDLE;
                            drop = 1'b1;
                        end
                    end
                    MODE_DATA:
                    begin
                        if (ext && position == EXT_LOW_POS)
                        begin
                            exp_len = exp_len + LEN_W'(b);
                        end
                        else if (ext && position == EXT_HIGH_POS)
                        begin
                            exp_len = exp_len + (LEN_W'(b) << 8) + EXT_EXTRA;
                            drop    = (exp_len > LEN_W'(limit));
                        end
                        r.write_valid    = 1'b1;
                        r.write_position = position[POS_W-1:0];
                        r.write_value    = b;
                        position         = position + 1'b1;
                        if (drop)
                        begin
                            mode = MODE_IDLE;
                        end
                        else if (position >= exp_len)
                        begin
                            mode             = MODE_END;
                            r.frame_complete = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            r.frame_length  = exp_len;
            r.frame_dropped = drop;
            pending_q.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            words_checked++;
            if (pending_q.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("result word %0d arrived with nothing expected: %h",
                             words_checked, got);
            end
            else
            begin
                want = pending_q.pop_front();
                if (got.write_valid !== want.write_valid
                    || got.write_position !== want.write_position
                    || got.write_value !== want.write_value
                    || got.frame_complete !== want.frame_complete
                    || got.frame_length !== want.frame_length
                    || got.frame_dropped !== want.frame_dropped)
                begin
                    failures++;
                    if (failures <= 10)
                    begin
                        $display("word %0d expected: wv %0d pos %0d val %h done %0d len %0d drop %0d",
                                 words_checked, want.write_valid, want.write_position,
                                 want.write_value, want.frame_complete, want.frame_length,
                                 want.frame_dropped);
                        $display("word %0d actual:   wv %0d pos %0d val %h done %0d len %0d drop %0d",
                                 words_checked, got.write_valid, got.write_position,
                                 got.write_value, got.frame_complete, got.frame_length,
                                 got.frame_dropped);
                    end
                end
            end
        endfunction
    endclass

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [APB_W-1:0]    pwdata   = '0;
    logic [APB_W-1:0]    prdata;
    logic                pready;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [BYTE_W-1:0]   s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;

    frame_scoreboard sb = new();
    bit              sender_fast   = 1'b0;
    bit              receiver_fast = 1'b0;
    int              words_sent    = 0;

    serial_frame_deframer i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("tb_serial_frame_deframer failed");
        $finish;
    end

    function automatic int draw_wait(bit fast);
        return fast ? 0 : $urandom_range(0, 17);
    endfunction

    initial
    begin : result_monitor
        int      stall;
        result_t word;
        forever
        begin
            stall = draw_wait(receiver_fast);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(negedge clk); while (m_tvalid !== 1'b1);
            word = result_t'(m_tdata);
            @(posedge clk);
            sb.check_result(word);
        end
    end

    // Leaves psel high so that the next write can start its setup cycle at once.
    task automatic write_reg(input reg_index_t idx, input logic [APB_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(negedge clk); while (pready !== 1'b1);
        @(posedge clk);
        sb.set_register(idx, value);
    endtask

    task automatic configure(input logic [7:0] first, input logic [7:0] second,
                             input logic [7:0] min_v, input logic [7:0] max_v,
                             input logic [15:0] limit_v);
        write_reg(REG_FIRST_HEADER, APB_W'(first));
        write_reg(REG_SECOND_HEADER, APB_W'(second));
        write_reg(REG_MIN_LEN, APB_W'(min_v));
        write_reg(REG_MAX_LEN, APB_W'(max_v));
        write_reg(REG_BUFFER_LIMIT, APB_W'(limit_v));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Leaves tvalid high after acceptance so that a back-to-back word needs no second update.
    task automatic send_word(input logic kind, input logic [BYTE_W-1:0] b);
        int gap;
        gap = draw_wait(sender_fast);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= b;
        do @(negedge clk); while (s_tready !== 1'b1);
        @(posedge clk);
        sb.note_word(kind, b);
        words_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_noise(input int count);
        logic [BYTE_W-1:0] b;
        repeat (count)
        begin
            b = ($urandom_range(0, 3) == 0) ? sb.first_hdr : 8'($urandom);
            send_word(($urandom_range(0, 7) == 0) ? KIND_RELEASE : KIND_BYTE, b);
        end
    endtask

    task automatic random_frame();
        int                lo;
        int                hi;
        int                pick;
        logic [BYTE_W-1:0] b;
        send_word(KIND_BYTE, sb.first_hdr);
        if ($urandom_range(0, 5) == 0)
            send_word(KIND_BYTE, sb.first_hdr);
        send_word(KIND_BYTE, ($urandom_range(0, 9) == 0) ? 8'($urandom) : sb.second_hdr);
        pick = $urandom_range(0, 99);
        lo   = sb.min_len;
        hi   = sb.max_len;
        if (pick < 60 && lo <= hi)
        begin
            if (hi > lo + 20 && $urandom_range(0, 7) != 0)
                hi = lo + 20;
            b = 8'($urandom_range(hi, lo));
        end
        else if (pick < 80)
            b = '0;
        else
            b = 8'($urandom);
        send_word(KIND_BYTE, b);
        while (sb.mode == MODE_DATA)
        begin
            if (sb.ext && sb.position == EXT_HIGH_POS)
                b = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 3)) : 8'd0;
            else
                b = 8'($urandom);
            send_word(($urandom_range(0, 59) == 0) ? KIND_RELEASE : KIND_BYTE, b);
        end
        if (sb.mode == MODE_END)
        begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) send_word(KIND_BYTE, 8'($urandom));
            if ($urandom_range(0, 9) != 0)
                send_word(KIND_RELEASE, 8'($urandom));
        end
    endtask

    task automatic run_phase(input int count);
        int stop_at;
        int pick;
        stop_at       = words_sent + count;
        sender_fast   = ($urandom_range(0, 3) == 0);
        receiver_fast = ($urandom_range(0, 3) == 0);
        while (words_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                random_frame();
            else if (pick < 90)
                send_noise($urandom_range(1, 4));
            else
                send_word(KIND_RELEASE, 8'($urandom));
            if ($urandom_range(0, 19) == 0)
                drain();
        end
        drain();
        sender_fast   = 1'b0;
        receiver_fast = 1'b0;
    endtask

    initial
    begin : stimulus
        int         p;
        logic [7:0] first;
        logic [7:0] min_v;
        int         max_v;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Broken headers, a length above the maximum and an extended frame over the limit.
        configure(8'hA5, 8'h5A, 8'd8, 8'd16, 16'd20);
        send_word(KIND_BYTE, 8'h00);
        send_word(KIND_RELEASE, 8'hFF);
        send_word(KIND_BYTE, 8'hA5);
        send_word(KIND_BYTE, 8'hA5);
        send_word(KIND_BYTE, 8'h5A);
        send_word(KIND_BYTE, 8'h11);
        send_word(KIND_BYTE, 8'hA5);
        send_word(KIND_BYTE, 8'h33);
        send_word(KIND_BYTE, 8'hA5);
        send_word(KIND_BYTE, 8'h5A);
        send_word(KIND_BYTE, 8'h00);
        for (p = 3; p < 9; p++)
            send_word(KIND_BYTE, (p % 2 == 0) ? 8'hFF : 8'h80);
        send_word(KIND_BYTE, 8'hFF);
        send_word(KIND_BYTE, 8'h01);
        drain();

        // Equal headers, then a zero length with a zero minimum that completes on its first data byte.
        configure(8'hFF, 8'hFF, 8'd0, 8'd1, 16'hFFFF);
        send_word(KIND_BYTE, 8'hFF);
        send_word(KIND_BYTE, 8'hFF);
        send_word(KIND_BYTE, 8'h00);
        send_word(KIND_BYTE, 8'h00);
        send_word(KIND_BYTE, 8'hAB);
        send_word(KIND_RELEASE, 8'h00);
        drain();

        configure(8'h00, 8'hFF, 8'd0, 8'd255, 16'd0);
        run_phase(115);
        configure(8'hFF, 8'hFF, 8'd255, 8'd255, 16'hFFFF);
        run_phase(115);
        configure(8'h7E, 8'h81, 8'd200, 8'd10, 16'd300);
        run_phase(115);
        for (p = 0; p < 7; p++)
        begin
            first = 8'($urandom);
            min_v = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20));
            max_v = int'(min_v) + $urandom_range(0, 40);
            if (max_v > 255)
                max_v = 255;
            configure(first, ($urandom_range(0, 4) == 0) ? first : 8'($urandom), min_v,
                      8'(max_v),
                      ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 700)));
            run_phase(115);
        end

        drain();
        repeat (10) @(posedge clk);
        if (sb.failures == 0 && sb.pending_q.size() == 0)
            $display("tb_serial_frame_deframer passed");
        else
            $display("tb_serial_frame_deframer failed");
        $finish;
    end

endmodule
